### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the permutation parity engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define PPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check on every clock edge, reset included
`define PPE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Types and constants of the permutation parity engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

	localparam int ELEMENT_W = 6;
	localparam int LENGTH_W  = 7;

	typedef struct packed {
		logic [ELEMENT_W-1:0] element;
		logic                 last;
	} item_t;

	typedef struct packed {
		logic                parity;
		logic                error;
		logic [LENGTH_W-1:0] length;
	} result_t;

	typedef struct packed {
		logic                 visited;
		logic [ELEMENT_W-1:0] element;
	} entry_t;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_RD   = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

### hdl/ppe_tag_ram.sv
// ----------------------------------------------------------------------------
// ppe_tag_ram
// Element store with visited tag: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ppe_tag_ram import ppe_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output entry_t                   rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/permutation_parity_engine_unit.sv
// ----------------------------------------------------------------------------
// permutation_parity_engine_unit
// Loads a permutation one element per transaction, then walks its cycles
// through the tag store and returns the sign with length and error flag.
//
//   channel  dir  payload   handshake
//   item     in   item_t    item_valid / item_stall
//   result   out  result_t  result_valid / result_stall
//
// Loading accepts one element per cycle. After the last element the walk
// reads the store once per start index plus once per tagged element, each
// read passing through a read state and then a check state; the single
// store read port limits the walk, and the result is then handed over.
// Reset clears the control state; store entries are cleared as they load.
// item_stall is high from the walk until the result register takes the result;
// a pending result does not block loading.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module permutation_parity_engine_unit import ppe_pkg::*; #(
	parameter int MAX_LEN = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IW   = $clog2(MAX_LEN);
	localparam int CW   = $clog2(MAX_LEN + 1);
	localparam int CMPW = (CW > ELEMENT_W) ? CW : ELEMENT_W;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   i_q;
	logic [IW-1:0]   j_q;
	logic            ovf_q;
	logic            par_q;
	logic            bad_q;
	logic            result_valid_q;
	result_t         result_q;

	logic            item_acc;
	logic            room;
	logic            nxt_out;
	logic [CW-1:0]   i_nx;
	logic            i_end;
	logic            out_free;
	logic            err;

	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;
	logic            rd_en;
	entry_t          rd_data;

	assign item_stall = (state_q != ST_LOAD);
	assign item_acc   = item_valid && (state_q == ST_LOAD);
	assign room       = cnt_q < CW'(MAX_LEN);
	assign nxt_out    = CMPW'(rd_data.element) >= CMPW'(cnt_q);
	assign i_nx       = i_q + CW'(1);
	assign i_end      = (i_nx == cnt_q);
	assign out_free   = !result_valid_q || !result_stall;
	assign err        = bad_q || ovf_q;

	always_comb begin
		wr_en           = (item_acc && room) || ((state_q == ST_CHK) && !rd_data.visited);
		wr_addr         = cnt_q[IW-1:0];
		wr_data.visited = 1'b0;
		wr_data.element = item.element;
		if (state_q == ST_CHK) begin
			wr_addr         = j_q;
			wr_data.visited = 1'b1;
			wr_data.element = rd_data.element;
		end
	end

	assign rd_en = (state_q == ST_RD);

	ppe_tag_ram #(
		.DEPTH(MAX_LEN)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(j_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			cnt_q          <= '0;
			i_q            <= '0;
			j_q            <= '0;
			ovf_q          <= 1'b0;
			par_q          <= 1'b0;
			bad_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (item_acc) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							i_q     <= '0;
							j_q     <= '0;
							par_q   <= 1'b0;
							bad_q   <= 1'b0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!rd_data.visited && !nxt_out) begin
						// follow the cycle
						if (CW'(j_q) != i_q) begin
							par_q <= ~par_q;
						end
						j_q     <= IW'(rd_data.element);
						state_q <= ST_RD;
					end else begin
						if (!rd_data.visited) begin
							bad_q <= 1'b1;
							if (CW'(j_q) != i_q) begin
								par_q <= ~par_q;
							end
						end
						// advance to the next start index, or finish after the last one
						if (i_end) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_nx;
							j_q     <= i_nx[IW-1:0];
							state_q <= ST_RD;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						par_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			result_q.parity <= par_q && !err;
			result_q.error  <= err;
			result_q.length <= LENGTH_W'(cnt_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`PPE_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_LEN), "element count above capacity")
	`PPE_ASSERT(a_walk_index, (state_q == ST_CHK) |-> (CW'(j_q) < cnt_q),
		"walk index beyond loaded length")
	`PPE_ASSERT(a_result_src, $rose(result_valid) |-> $past(state_q == ST_DONE),
		"result raised outside hand-over")
	`PPE_ASSERT(a_err_parity, result_valid |-> !(result.error && result.parity),
		"parity set on an errored result")

endmodule
